FILE: rtl/hcpu_pkg.sv
// ----------------------------------------------------------------------------
// hcpu_pkg
// Shared constants and types for the Hack instruction step block.
// ----------------------------------------------------------------------------
package hcpu_pkg;

	localparam int WORD_W              = 16;
	localparam int DATA_ADDR_BITS_DEF  = 15;
	localparam int MEM_ADDR_OUT_W      = 15;
	localparam int STATUS_W            = 3;

	localparam logic [WORD_W-1:0] HALT_PC  = 16'hFFFF;
	localparam logic [WORD_W-1:0] NOP_WORD = 16'hFFFF;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_COMP = 3'd3;
	localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd4;

	typedef struct packed {
		logic              ok;
		logic              jump;
		logic [WORD_W-1:0] value;
	} alu_res_t;

endpackage

FILE: rtl/hcpu_dmem.sv
// ----------------------------------------------------------------------------
// hcpu_dmem
// Data memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hcpu_dmem #(
	parameter int DATA_ADDR_BITS = hcpu_pkg::DATA_ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [DATA_ADDR_BITS-1:0]       waddr,
	input  logic [hcpu_pkg::WORD_W-1:0]     wdata,
	input  logic                            re,
	input  logic [DATA_ADDR_BITS-1:0]       raddr,
	output logic [hcpu_pkg::WORD_W-1:0]     rdata
);

	localparam int DEPTH = 1 << DATA_ADDR_BITS;

	logic [hcpu_pkg::WORD_W-1:0] mem [DEPTH];
	logic [hcpu_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/hcpu_alu.sv
// ----------------------------------------------------------------------------
// hcpu_alu
// Comp decode, ALU function and jump condition of a C-instruction.
// ----------------------------------------------------------------------------
module hcpu_alu (
	input  logic [hcpu_pkg::WORD_W-1:0] instruction,
	input  logic [hcpu_pkg::WORD_W-1:0] d,
	input  logic [hcpu_pkg::WORD_W-1:0] y,
	output hcpu_pkg::alu_res_t          res
);

	localparam logic [5:0] COMP_ZERO    = 6'b101010;
	localparam logic [5:0] COMP_ONE     = 6'b111111;
	localparam logic [5:0] COMP_NEG_ONE = 6'b111010;
	localparam logic [5:0] COMP_D       = 6'b001100;
	localparam logic [5:0] COMP_Y       = 6'b110000;
	localparam logic [5:0] COMP_NOT_D   = 6'b001101;
	localparam logic [5:0] COMP_NOT_Y   = 6'b110001;
	localparam logic [5:0] COMP_NEG_D   = 6'b001111;
	localparam logic [5:0] COMP_NEG_Y   = 6'b110011;
	localparam logic [5:0] COMP_D_INC   = 6'b011111;
	localparam logic [5:0] COMP_Y_INC   = 6'b110111;
	localparam logic [5:0] COMP_D_DEC   = 6'b001110;
	localparam logic [5:0] COMP_Y_DEC   = 6'b110010;
	localparam logic [5:0] COMP_D_ADD_Y = 6'b000010;
	localparam logic [5:0] COMP_D_SUB_Y = 6'b010011;
	localparam logic [5:0] COMP_Y_SUB_D = 6'b000111;
	localparam logic [5:0] COMP_D_AND_Y = 6'b000000;
	localparam logic [5:0] COMP_D_OR_Y  = 6'b010101;

	localparam logic [2:0] JMP_NULL = 3'd0;
	localparam logic [2:0] JMP_GT   = 3'd1;
	localparam logic [2:0] JMP_EQ   = 3'd2;
	localparam logic [2:0] JMP_GE   = 3'd3;
	localparam logic [2:0] JMP_LT   = 3'd4;
	localparam logic [2:0] JMP_NE   = 3'd5;
	localparam logic [2:0] JMP_LE   = 3'd6;
	localparam logic [2:0] JMP_ALW  = 3'd7;

	localparam logic [hcpu_pkg::WORD_W-1:0] ONE = 16'd1;

	logic [6:0]                  code;
	logic [hcpu_pkg::WORD_W-1:0] value;
	logic                        ok;
	logic                        neg;
	logic                        zero;
	logic                        jump;

	assign code = instruction[12:6];

	always_comb begin
		ok    = 1'b1;
		value = '0;
		case (code)
			{1'b0, COMP_ZERO}:    value = '0;
			{1'b0, COMP_ONE}:     value = ONE;
			{1'b0, COMP_NEG_ONE}: value = '1;
			{1'b0, COMP_D}:       value = d;
			{1'b0, COMP_Y},
			{1'b1, COMP_Y}:       value = y;
			{1'b0, COMP_NOT_D}:   value = ~d;
			{1'b0, COMP_NOT_Y},
			{1'b1, COMP_NOT_Y}:   value = ~y;
			{1'b0, COMP_NEG_D}:   value = '0 - d;
			{1'b0, COMP_NEG_Y},
			{1'b1, COMP_NEG_Y}:   value = '0 - y;
			{1'b0, COMP_D_INC}:   value = d + ONE;
			{1'b0, COMP_Y_INC},
			{1'b1, COMP_Y_INC}:   value = y + ONE;
			{1'b0, COMP_D_DEC}:   value = d - ONE;
			{1'b0, COMP_Y_DEC},
			{1'b1, COMP_Y_DEC}:   value = y - ONE;
			{1'b0, COMP_D_ADD_Y},
			{1'b1, COMP_D_ADD_Y}: value = d + y;
			{1'b0, COMP_D_SUB_Y},
			{1'b1, COMP_D_SUB_Y}: value = d - y;
			{1'b0, COMP_Y_SUB_D},
			{1'b1, COMP_Y_SUB_D}: value = y - d;
			{1'b0, COMP_D_AND_Y},
			{1'b1, COMP_D_AND_Y}: value = d & y;
			{1'b0, COMP_D_OR_Y},
			{1'b1, COMP_D_OR_Y}:  value = d | y;
			default:              ok = 1'b0;
		endcase
	end

	assign neg  = value[hcpu_pkg::WORD_W-1];
	assign zero = (value == '0);

	always_comb begin
		case (instruction[2:0])
			JMP_NULL: jump = 1'b0;
			JMP_GT:   jump = !neg && !zero;
			JMP_EQ:   jump = zero;
			JMP_GE:   jump = !neg;
			JMP_LT:   jump = neg;
			JMP_NE:   jump = !zero;
			JMP_LE:   jump = neg || zero;
			JMP_ALW:  jump = 1'b1;
			default:  jump = 1'b0;
		endcase
	end

	assign res.ok    = ok;
	assign res.jump  = jump;
	assign res.value = value;

endmodule

FILE: rtl/accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// Hack instruction step: A, D and PC in registers, data memory in RAM.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | instruction
//  out     | out_valid / out_stall | status next_pc a_value d_value alu_value
//          |                       | mem_written mem_address mem_data
//
//  The accept cycle issues the RAM read at A; the execute stage then writes back
//  A, D, PC and memory when the output register can take its result, and no
//  new instruction is taken before that. After reset a clearing pass zeroes
//  all 2**DATA_ADDR_BITS RAM words (32768 at the default), with in_stall high throughout.
//  A result waits in the output register while out_stall is high; a further
//  instruction may be taken meanwhile and waits in the execute stage.
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
	parameter int DATA_ADDR_BITS = hcpu_pkg::DATA_ADDR_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [hcpu_pkg::WORD_W-1:0]              instruction,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [hcpu_pkg::STATUS_W-1:0]            status,
	output logic [hcpu_pkg::WORD_W-1:0]              next_pc,
	output logic signed [hcpu_pkg::WORD_W-1:0]       a_value,
	output logic signed [hcpu_pkg::WORD_W-1:0]       d_value,
	output logic signed [hcpu_pkg::WORD_W-1:0]       alu_value,
	output logic                                     mem_written,
	output logic [hcpu_pkg::MEM_ADDR_OUT_W-1:0]      mem_address,
	output logic signed [hcpu_pkg::WORD_W-1:0]       mem_data
);

	localparam int W = hcpu_pkg::WORD_W;
	localparam logic [DATA_ADDR_BITS-1:0] ADDR_ONE = {{(DATA_ADDR_BITS-1){1'b0}}, 1'b1};
	localparam logic [W-1:0] PC_ONE = 16'd1;

	logic [W-1:0]                a_q, d_q, pc_q;
	logic                        clr_busy_q;
	logic [DATA_ADDR_BITS-1:0]   clr_addr_q;
	logic                        s1_valid_q;
	logic [W-1:0]                instr_s1;
	logic                        out_valid_q;

	logic [hcpu_pkg::STATUS_W-1:0]        status_q;
	logic [W-1:0]                         next_pc_q, a_out_q, d_out_q, alu_out_q, mem_data_q;
	logic                                 mem_written_q;
	logic [hcpu_pkg::MEM_ADDR_OUT_W-1:0]  mem_address_q;

	logic                        in_fire;
	logic                        s1_fire;
	logic [DATA_ADDR_BITS-1:0]   exec_addr;
	logic [W-1:0]                addr_ext;
	logic [W-1:0]                rdata;
	logic [W-1:0]                y;
	hcpu_pkg::alu_res_t          alu_res;

	logic [hcpu_pkg::STATUS_W-1:0] ex_status;
	logic [W-1:0]                  ex_pc, ex_a, ex_d, ex_alu;
	logic                          ex_wr;

	logic                        mem_we;
	logic [DATA_ADDR_BITS-1:0]   mem_waddr;
	logic [W-1:0]                mem_wdata;

	assign in_stall  = clr_busy_q || s1_valid_q;
	assign in_fire   = in_valid && !in_stall;
	assign s1_fire   = s1_valid_q && (!out_valid_q || !out_stall);
	assign exec_addr = a_q[DATA_ADDR_BITS-1:0];
	assign addr_ext  = W'(exec_addr);
	assign y         = instr_s1[12] ? rdata : a_q;

	hcpu_dmem #(
		.DATA_ADDR_BITS(DATA_ADDR_BITS)
	) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_fire),
		.raddr (exec_addr),
		.rdata (rdata)
	);

	hcpu_alu u_alu (
		.instruction (instr_s1),
		.d           (d_q),
		.y           (y),
		.res         (alu_res)
	);

	always_comb begin
		ex_status = hcpu_pkg::ST_OK;
		ex_pc     = pc_q;
		ex_a      = a_q;
		ex_d      = d_q;
		ex_alu    = '0;
		ex_wr     = 1'b0;
		if (pc_q == hcpu_pkg::HALT_PC) begin
			ex_status = hcpu_pkg::ST_HALTED;
		end else if (instr_s1 == hcpu_pkg::NOP_WORD) begin
			ex_status = hcpu_pkg::ST_NOP;
		end else if (!instr_s1[15]) begin
			ex_a  = instr_s1;
			ex_pc = pc_q + PC_ONE;
		end else if (instr_s1[14:13] != 2'b11) begin
			ex_status = hcpu_pkg::ST_BAD_TYPE;
		end else if (!alu_res.ok) begin
			ex_status = hcpu_pkg::ST_BAD_COMP;
		end else begin
			ex_alu = alu_res.value;
			ex_pc  = alu_res.jump ? a_q : pc_q + PC_ONE;
			ex_wr  = instr_s1[3];
			if (instr_s1[4]) begin
				ex_d = alu_res.value;
			end
			if (instr_s1[5]) begin
				ex_a = alu_res.value;
			end
		end
	end

	// clearing pass owns the write port until it finishes
	assign mem_we    = clr_busy_q || (s1_fire && ex_wr);
	assign mem_waddr = clr_busy_q ? clr_addr_q : exec_addr;
	assign mem_wdata = clr_busy_q ? '0 : alu_res.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_ONE;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			instr_s1 <= instruction;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= '0;
			d_q  <= '0;
			pc_q <= '0;
		end else if (s1_fire) begin
			a_q  <= ex_a;
			d_q  <= ex_d;
			pc_q <= ex_pc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q      <= ex_status;
			next_pc_q     <= ex_pc;
			a_out_q       <= ex_a;
			d_out_q       <= ex_d;
			alu_out_q     <= ex_alu;
			mem_written_q <= ex_wr;
			mem_address_q <= ex_wr ? addr_ext[hcpu_pkg::MEM_ADDR_OUT_W-1:0] : '0;
			mem_data_q    <= ex_wr ? alu_res.value : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign next_pc     = next_pc_q;
	assign a_value     = $signed(a_out_q);
	assign d_value     = $signed(d_out_q);
	assign alu_value   = $signed(alu_out_q);
	assign mem_written = mem_written_q;
	assign mem_address = mem_address_q;
	assign mem_data    = $signed(mem_data_q);

	// A must not move between the RAM read and the execute cycle
	a_stable_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> s1_valid_q && $stable(a_q))
		else $error("A changed before execute of a transferred instruction");

	s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |=> s1_valid_q && $stable(instr_s1) && $stable(pc_q))
		else $error("execute stage lost or altered a waiting instruction");

	clear_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> clr_addr_q == '0 && !s1_valid_q)
		else $error("clearing pass ended off the wrap point");

	no_write_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && ex_status != hcpu_pkg::ST_OK |-> !ex_wr && ex_pc == pc_q)
		else $error("state changed on a rejected instruction");

	halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && pc_q == hcpu_pkg::HALT_PC |=> pc_q == hcpu_pkg::HALT_PC)
		else $error("halted block left the halt address");

endmodule
